@@ rtl/lnds_pkg.sv @@
// Shared types and constants for the longest non-decreasing subsequence block.
// Used by lnds_ctrl, lnds_dp and the top level longest_nondecreasing_subsequence.
package lnds_pkg;

	localparam int MAX_ITEMS_DEF  = 64;
	localparam int VALUE_BITS_DEF = 32;
	localparam int POS_W          = 6;
	localparam int LEN_W          = 7;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MID,
		ST_TAIL,
		ST_CMP,
		ST_COMMIT,
		ST_WTAIL,
		ST_WCUR,
		ST_WLINK,
		ST_WLOAD,
		ST_WOUT
	} state_t;

	typedef enum logic [1:0] {
		TSEL_MID,
		TSEL_PREV,
		TSEL_LAST
	} tail_sel_t;

	typedef struct packed {
		logic      load_item;
		logic      mark_ovf;
		logic      step;
		logic      commit;
		logic      take_tail;
		logic      load_out;
		logic      advance;
		logic      clear;
		tail_sel_t tail_sel;
	} cmd_t;

	typedef struct packed {
		logic search_done;
		logic full;
		logic fin;
		logic walk_empty;
		logic last;
	} sts_t;

endpackage

@@ rtl/lnds_ctrl.sv @@
// Controller state machine for the subsequence block: sequences the search,
// the store update and the link walk. Depends on lnds_pkg.
module lnds_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            out_ready,
	input  lnds_pkg::sts_t  sts,
	output logic            in_ready,
	output logic            out_valid,
	output lnds_pkg::cmd_t  cmd
);

	lnds_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lnds_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lnds_pkg::ST_IDLE: begin
				if (in_valid) state_d = lnds_pkg::ST_CHECK;
			end
			lnds_pkg::ST_CHECK: begin
				if (!sts.full) state_d = lnds_pkg::ST_MID;
				else if (sts.fin) state_d = lnds_pkg::ST_WTAIL;
				else state_d = lnds_pkg::ST_IDLE;
			end
			lnds_pkg::ST_MID: begin
				state_d = sts.search_done ? lnds_pkg::ST_COMMIT : lnds_pkg::ST_TAIL;
			end
			lnds_pkg::ST_TAIL:   state_d = lnds_pkg::ST_CMP;
			lnds_pkg::ST_CMP:    state_d = lnds_pkg::ST_MID;
			lnds_pkg::ST_COMMIT: begin
				state_d = sts.fin ? lnds_pkg::ST_WTAIL : lnds_pkg::ST_IDLE;
			end
			lnds_pkg::ST_WTAIL: begin
				state_d = sts.walk_empty ? lnds_pkg::ST_IDLE : lnds_pkg::ST_WCUR;
			end
			lnds_pkg::ST_WCUR:  state_d = lnds_pkg::ST_WLINK;
			lnds_pkg::ST_WLINK: state_d = lnds_pkg::ST_WLOAD;
			lnds_pkg::ST_WLOAD: state_d = lnds_pkg::ST_WOUT;
			lnds_pkg::ST_WOUT: begin
				if (out_ready) state_d = sts.last ? lnds_pkg::ST_IDLE : lnds_pkg::ST_WLINK;
			end
			default: state_d = lnds_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.tail_sel  = lnds_pkg::TSEL_MID;
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		unique case (state_q)
			lnds_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_item = in_valid;
			end
			lnds_pkg::ST_CHECK: begin
				cmd.mark_ovf = sts.full;
			end
			lnds_pkg::ST_MID: begin
				// Once the search closes, fetch the tail of the pile to the left.
				cmd.tail_sel = sts.search_done ? lnds_pkg::TSEL_PREV : lnds_pkg::TSEL_MID;
			end
			lnds_pkg::ST_TAIL: begin
			end
			lnds_pkg::ST_CMP: begin
				cmd.step = 1'b1;
			end
			lnds_pkg::ST_COMMIT: begin
				cmd.commit = 1'b1;
			end
			lnds_pkg::ST_WTAIL: begin
				cmd.tail_sel = lnds_pkg::TSEL_LAST;
				cmd.clear    = sts.walk_empty;
			end
			lnds_pkg::ST_WCUR: begin
				cmd.take_tail = 1'b1;
			end
			lnds_pkg::ST_WLINK: begin
			end
			lnds_pkg::ST_WLOAD: begin
				cmd.load_out = 1'b1;
			end
			lnds_pkg::ST_WOUT: begin
				out_valid   = 1'b1;
				cmd.advance = out_ready && !sts.last;
				cmd.clear   = out_ready && sts.last;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ rtl/lnds_dp.sv @@
// Datapath for the subsequence block: value, pile-tail and link memories,
// search bounds, counters and the result register. Depends on lnds_pkg.
module lnds_dp #(
	parameter int MAX_ITEMS  = lnds_pkg::MAX_ITEMS_DEF,
	parameter int VALUE_BITS = lnds_pkg::VALUE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic signed [VALUE_BITS-1:0]         value,
	input  logic                                 is_final,
	input  lnds_pkg::cmd_t                       cmd,
	output lnds_pkg::sts_t                       sts,
	output logic        [lnds_pkg::POS_W-1:0]    position,
	output logic        [lnds_pkg::LEN_W-1:0]    chain_length,
	output logic                                 overflow,
	output logic                                 end_of_run
);

	localparam int IDX_W = $clog2(MAX_ITEMS);
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	logic signed [VALUE_BITS-1:0] value_mem [MAX_ITEMS];
	logic        [IDX_W-1:0]      tail_mem  [MAX_ITEMS];
	logic        [IDX_W:0]        link_mem  [MAX_ITEMS];

	logic signed [VALUE_BITS-1:0] val_rd_q;
	logic        [IDX_W-1:0]      tail_rd_q;
	logic        [IDX_W:0]        link_rd_q;
	logic        [IDX_W-1:0]      tail_addr;

	logic signed [VALUE_BITS-1:0] value_q;
	logic                         fin_q;
	logic [CNT_W-1:0]             lo_q, hi_q;
	logic [CNT_W-1:0]             tail_count_q, item_count_q;
	logic                         ovf_q;
	logic [IDX_W-1:0]             cur_q;
	logic [CNT_W-1:0]             steps_q;
	logic [IDX_W-1:0]             out_pos_q;
	logic                         out_end_q;

	logic [CNT_W:0]               mid_sum;
	logic [CNT_W-1:0]             mid;
	logic [CNT_W-1:0]             prev;
	logic [CNT_W-1:0]             last_pile;
	logic [CNT_W-1:0]             steps_inc;
	logic                         key_le;

	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid       = mid_sum[CNT_W:1];
	assign prev      = lo_q - CNT_W'(1);
	assign last_pile = tail_count_q - CNT_W'(1);
	assign steps_inc = steps_q + CNT_W'(1);
	assign key_le    = (val_rd_q <= value_q);

	always_comb begin
		case (cmd.tail_sel)
			lnds_pkg::TSEL_PREV: tail_addr = prev[IDX_W-1:0];
			lnds_pkg::TSEL_LAST: tail_addr = last_pile[IDX_W-1:0];
			default:             tail_addr = mid[IDX_W-1:0];
		endcase
	end

	// Memories: one write port and one registered read port each. The value
	// memory is addressed by the tail just read, the link memory by the walk cursor.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			value_mem[item_count_q[IDX_W-1:0]] <= value_q;
			tail_mem[lo_q[IDX_W-1:0]]          <= item_count_q[IDX_W-1:0];
			link_mem[item_count_q[IDX_W-1:0]]  <= {(lo_q == '0), tail_rd_q};
		end
		tail_rd_q <= tail_mem[tail_addr];
		val_rd_q  <= value_mem[tail_rd_q];
		link_rd_q <= link_mem[cur_q];
	end

	// Search bounds, walk cursor and result payload.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			value_q <= value;
			fin_q   <= is_final;
			lo_q    <= '0;
			hi_q    <= tail_count_q;
		end
		if (cmd.step) begin
			if (key_le) lo_q <= mid + CNT_W'(1);
			else hi_q <= mid;
		end
		if (cmd.take_tail) begin
			cur_q   <= tail_rd_q;
			steps_q <= '0;
		end
		if (cmd.advance) begin
			cur_q   <= link_rd_q[IDX_W-1:0];
			steps_q <= steps_inc;
		end
		if (cmd.load_out) begin
			out_pos_q <= cur_q;
			out_end_q <= link_rd_q[IDX_W] || (steps_inc >= CNT_W'(MAX_ITEMS));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_count_q <= '0;
			item_count_q <= '0;
			ovf_q        <= 1'b0;
		end else if (cmd.clear) begin
			tail_count_q <= '0;
			item_count_q <= '0;
			ovf_q        <= 1'b0;
		end else begin
			if (cmd.mark_ovf) ovf_q <= 1'b1;
			if (cmd.commit) begin
				item_count_q <= item_count_q + CNT_W'(1);
				if (lo_q >= tail_count_q) tail_count_q <= lo_q + CNT_W'(1);
			end
		end
	end

	assign sts.search_done = (lo_q >= hi_q);
	assign sts.full        = (item_count_q == CNT_W'(MAX_ITEMS));
	assign sts.fin         = fin_q;
	assign sts.walk_empty  = (tail_count_q == '0);
	assign sts.last        = out_end_q;

	assign position     = lnds_pkg::POS_W'(out_pos_q);
	assign chain_length = lnds_pkg::LEN_W'(tail_count_q);
	assign overflow     = ovf_q;
	assign end_of_run   = out_end_q;

endmodule

@@ rtl/longest_nondecreasing_subsequence.sv @@
// Longest non-decreasing subsequence, top level: controller plus datapath.
// Depends on lnds_pkg, lnds_ctrl and lnds_dp.
//
// Feed one signed value per transfer; mark the last one with is_final. Each
// stored item runs a binary search over the current piles, of at most 6
// probes since no more than 63 piles exist while an item is being stored,
// and every probe reads the pile-tail memory and then the value memory
// through their single registered read ports. An item that arrives when
// MAX_ITEMS are already stored is dropped and sets overflow. After a final
// item has been stored or dropped, the first result is offered, and then
// the next ones follow while out_ready stays high, each after its link has
// been fetched, last index first; end_of_run marks the earliest index,
// after which the block is cleared and takes the next sequence. One item is
// worked on at a time, and no new item is taken during the walk.
module longest_nondecreasing_subsequence #(
	parameter int MAX_ITEMS  = lnds_pkg::MAX_ITEMS_DEF,
	parameter int VALUE_BITS = lnds_pkg::VALUE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [VALUE_BITS-1:0]      value,
	input  logic                              is_final,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic        [lnds_pkg::POS_W-1:0] position,
	output logic        [lnds_pkg::LEN_W-1:0] chain_length,
	output logic                              overflow,
	output logic                              end_of_run
);

	lnds_pkg::cmd_t cmd;
	lnds_pkg::sts_t sts;

	lnds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	lnds_dp #(
		.MAX_ITEMS  (MAX_ITEMS),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.value        (value),
		.is_final     (is_final),
		.cmd          (cmd),
		.sts          (sts),
		.position     (position),
		.chain_length (chain_length),
		.overflow     (overflow),
		.end_of_run   (end_of_run)
	);

	// The input side and the result side are never open in the same cycle.
	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a result is offered");

	// A result always reports at least one pile.
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (chain_length != '0))
		else $error("result offered with zero chain length");

	// The transfer of the closing result returns the block to accepting input.
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && end_of_run) |=> (in_ready && !out_valid))
		else $error("block not idle after the closing result");

	// Between two results of one walk there is a gap while the link is fetched.
	a_walk_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !end_of_run) |=> (!out_valid && !in_ready))
		else $error("walk did not fetch the next link");

endmodule
